// ===== hw/rtl/sattt_pkg.sv =====
// Shared types and constants for the set-associative transposition table.
package sattt_pkg;

    typedef enum logic [2:0] {
        FN_PROBE   = 3'd0,
        FN_STORE   = 3'd1,
        FN_ADVANCE = 3'd2,
        FN_CLEAR   = 3'd3,
        FN_OCCUPY  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_CLEAR,
        ST_OCC_READ,
        ST_OCC_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] mv;
        logic [15:0] score;
        logic [7:0]  depth;
        logic [1:0]  kind;
        logic [7:0]  age;
    } entry_t;

    localparam logic [1:0]   EXACT_KIND = 2'd3;
    localparam int           SCORE_LIMIT = 32000;
    localparam logic [15:0]  PERMILLE = 16'd1000;

endpackage

// ===== hw/rtl/sattt_cluster_mem.sv =====
// Cluster memory: one row holds every way of a cluster, with registered read data.
module sattt_cluster_mem
    import sattt_pkg::*;
#(
    parameter int CLUSTERS = 1024,
    parameter int WAYS = 8,
    localparam int AW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1
)
(
    input  logic                   clk,
    input  logic [AW-1:0]          raddr,
    output entry_t [WAYS-1:0]      rdata,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  entry_t [WAYS-1:0]      wdata
);

    entry_t [WAYS-1:0] mem [CLUSTERS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/sattt_way_select.sv =====
// Way logic: tag match, replacement choice and the updated cluster row.
module sattt_way_select
    import sattt_pkg::*;
#(
    parameter int WAYS = 8,
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1
)
(
    input  entry_t [WAYS-1:0] row,
    input  logic              is_store,
    input  logic [15:0]       tag,
    input  logic [7:0]        gen,
    input  logic signed [7:0] depth,
    input  logic [15:0]       score,
    input  logic [1:0]        kind,
    input  logic [15:0]       mv,
    output logic              found,
    output entry_t            found_entry,
    output entry_t [WAYS-1:0] new_row
);

    logic [WAYS-1:0] empty_w, match_w, stale_w;
    logic [WW-1:0]   mi, ei, si, li, pick;
    logic            any_e, any_s;
    logic signed [9:0] least;
    logic [15:0]     mv_eff;
    entry_t          fresh;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            empty_w[w] = (row[w] == '0);
            match_w[w] = !empty_w[w] && (row[w].tag == tag);
            stale_w[w] = (row[w].age != gen);
        end
        found = 1'b0;
        mi = '0;
        any_e = 1'b0;
        ei = '0;
        any_s = 1'b0;
        si = '0;
        li = '0;
        least = 10'sd511;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match_w[w])
            begin
                found = 1'b1;
                mi = WW'(w);
            end
            if (empty_w[w])
            begin
                any_e = 1'b1;
                ei = WW'(w);
            end
            if (stale_w[w])
            begin
                any_s = 1'b1;
                si = WW'(w);
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (10'(signed'(row[w].depth)) < least)
            begin
                least = 10'(signed'(row[w].depth));
                li = WW'(w);
            end
        end
        found_entry = row[mi];
        mv_eff = (found && mv == 16'd0) ? row[mi].mv : mv;
        fresh = '{tag: tag, mv: mv_eff, score: score, depth: depth, kind: kind, age: gen};
        pick = found ? mi : (any_e ? ei : (any_s ? si : li));
        new_row = row;
        if (!is_store)
        begin
            if (found)
            begin
                new_row[mi].age = gen;
            end
        end
        else if (found && (depth < signed'(row[mi].depth)) && (kind != EXACT_KIND))
        begin
            new_row[mi].mv = mv_eff;
            new_row[mi].age = gen;
        end
        else
        begin
            new_row[pick] = fresh;
        end
    end

endmodule

// ===== hw/rtl/set_associative_transposition_table.sv =====
// Top level of the set-associative transposition table.
//  channel | signals                                              | dir
//  request | start, func, key, req_depth, new_score, bound_kind,   | in
//          | new_move, stopped                                    |
//  result  | busy, done, found, hit, found_move, found_score,      | out
//          | found_kind, found_depth, occupancy_permille          |
// The next request can be accepted at the edge that ends the result strobe.
// Probe and store pass through the row read, the read-modify-write, the done state and the strobe.
// Advance and unused codes go straight to the done state. Clear sweeps one row a cycle.
// Occupancy reads one sampled row a cycle, then scales the count: reciprocal estimate, then correction.
// After reset a clearing pass runs with busy high and gives no result.
// The result strobe done lasts one cycle; the receiver cannot stall it.
// CLUSTERS must be a power of two (the block does not check it): the low key bits select the cluster.
module set_associative_transposition_table
    import sattt_pkg::*;
#(
    parameter int CLUSTERS = 1024,
    parameter int WAYS = 8,
    parameter int SAMPLES = 1000
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic [63:0]        key,
    input  logic signed [7:0]  req_depth,
    input  logic signed [31:0] new_score,
    input  logic [1:0]         bound_kind,
    input  logic [15:0]        new_move,
    input  logic               stopped,
    output logic               done,
    output logic               found,
    output logic               hit,
    output logic [15:0]        found_move,
    output logic signed [15:0] found_score,
    output logic [1:0]         found_kind,
    output logic signed [7:0]  found_depth,
    output logic [9:0]         occupancy_permille
);

    localparam int AW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int NS = (CLUSTERS < SAMPLES) ? CLUSTERS : SAMPLES;
    localparam int STRIDE = CLUSTERS / NS;
    localparam int NW = $clog2(NS + 1);
    localparam int FW = $clog2(NS * WAYS + 1);
    localparam int CW = $clog2(WAYS + 1);
    localparam int DENOM = NS * WAYS;
    localparam int QW = 10;
    localparam int RW = FW + 10;
    localparam int PW = FW + 11;
    localparam int RECIP = ((1 << FW) * 1000) / DENOM;

    state_t state_reg, state_next;
    logic [2:0]  func_reg;
    logic [15:0] tag_reg;
    logic [AW-1:0] idx_reg;
    logic signed [7:0] depth_reg;
    logic [15:0] score_reg, mv_reg;
    logic [1:0]  kind_reg;
    logic        stop_reg;
    logic [7:0]  gen_reg, gen_next;
    logic [AW:0] sweep_reg, sweep_next;
    logic        boot_reg, boot_next;
    logic [NW-1:0] samp_reg, samp_next;
    logic [FW-1:0] filled_reg, filled_next;
    logic        occ_valid_reg, occ_valid_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic        step_reg, step_next;
    logic        done_reg, done_next;
    logic        found_reg, hit_reg;
    entry_t      fe_reg;
    logic [QW-1:0] occ_out_reg;

    logic [AW-1:0] raddr, waddr;
    logic          we;
    entry_t [WAYS-1:0] rdata, wdata, new_row;
    logic          ws_found;
    entry_t        ws_entry;
    logic signed [15:0] score_sat;
    logic [CW-1:0] row_count;
    logic [AW-1:0] samp_addr;
    logic [AW-1:0] key_idx;
    logic [PW-1:0] scaled;
    logic [RW-1:0] resid;

    sattt_cluster_mem #(.CLUSTERS(CLUSTERS), .WAYS(WAYS)) u_mem (
        .clk(clk), .raddr(raddr), .rdata(rdata),
        .we(we), .waddr(waddr), .wdata(wdata)
    );

    sattt_way_select #(.WAYS(WAYS)) u_ways (
        .row(rdata), .is_store(func_reg == FN_STORE), .tag(tag_reg), .gen(gen_reg),
        .depth(depth_reg), .score(score_reg), .kind(kind_reg), .mv(mv_reg),
        .found(ws_found), .found_entry(ws_entry), .new_row(new_row)
    );

    always_comb
    begin
        if (new_score > 32'sd32000)
            score_sat = 16'sd32000;
        else if (new_score < -32'sd32000)
            score_sat = -16'sd32000;
        else
            score_sat = new_score[15:0];
        row_count = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            row_count = row_count + CW'(rdata[w] != '0);
        end
        samp_addr = AW'(samp_reg * STRIDE);
        key_idx = (CLUSTERS > 1) ? key[AW-1:0] : '0;
        scaled = PW'(filled_reg) * PW'(RECIP);
        resid = RW'(filled_reg) * RW'(PERMILLE) - RW'(quo_reg) * RW'(DENOM);
    end

    always_comb
    begin
        state_next = state_reg;
        gen_next = gen_reg;
        sweep_next = sweep_reg;
        boot_next = boot_reg;
        samp_next = samp_reg;
        filled_next = filled_reg;
        occ_valid_next = 1'b0;
        quo_next = quo_reg;
        step_next = step_reg;
        done_next = 1'b0;
        // hold the accepted cluster on the read port after the request is taken
        raddr = (state_reg == ST_IDLE) ? key_idx : idx_reg;
        waddr = idx_reg;
        wdata = new_row;
        we = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (func_t'(func))
                        FN_PROBE, FN_STORE: state_next = ST_READ;
                        FN_ADVANCE:
                        begin
                            gen_next = gen_reg + 8'd1;
                            state_next = ST_DONE;
                        end
                        FN_CLEAR:
                        begin
                            gen_next = '0;
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        FN_OCCUPY:
                        begin
                            samp_next = '0;
                            filled_next = '0;
                            state_next = ST_OCC_READ;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ: state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                we = (func_reg == FN_PROBE) ? ws_found : !stop_reg;
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                we = 1'b1;
                waddr = sweep_reg[AW-1:0];
                wdata = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == (AW+1)'(CLUSTERS - 1))
                begin
                    // the pass after reset answers no request
                    state_next = boot_reg ? ST_IDLE : ST_DONE;
                    boot_next = 1'b0;
                end
            end
            ST_OCC_READ:
            begin
                // issue one sample row a cycle, count the row issued in the cycle before
                raddr = samp_addr;
                if (occ_valid_reg)
                    filled_next = filled_reg + FW'(row_count);
                if (samp_reg != NW'(NS))
                begin
                    samp_next = samp_reg + 1'b1;
                    occ_valid_next = 1'b1;
                end
                else
                begin
                    quo_next = '0;
                    step_next = 1'b0;
                    state_next = ST_OCC_DIV;
                end
            end
            ST_OCC_DIV:
            begin
                // estimate with a fixed-point reciprocal, then correct by at most one
                if (!step_reg)
                begin
                    quo_next = QW'(scaled >> FW);
                    step_next = 1'b1;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            gen_reg <= '0;
            sweep_reg <= '0;
            boot_reg <= 1'b1;
            samp_reg <= '0;
            filled_reg <= '0;
            occ_valid_reg <= 1'b0;
            quo_reg <= '0;
            step_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg <= gen_next;
            sweep_reg <= sweep_next;
            boot_reg <= boot_next;
            samp_reg <= samp_next;
            filled_reg <= filled_next;
            occ_valid_reg <= occ_valid_next;
            quo_reg <= quo_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            func_reg <= func;
            tag_reg <= key[63:48];
            idx_reg <= key_idx;
            depth_reg <= req_depth;
            score_reg <= score_sat;
            kind_reg <= bound_kind;
            mv_reg <= new_move;
            stop_reg <= stopped;
            found_reg <= 1'b0;
            hit_reg <= 1'b0;
            fe_reg <= '0;
            occ_out_reg <= '0;
        end
        if (state_reg == ST_UPDATE && func_reg == FN_PROBE && ws_found)
        begin
            found_reg <= 1'b1;
            hit_reg <= signed'(ws_entry.depth) >= depth_reg;
            fe_reg <= ws_entry;
        end
        if (state_reg == ST_OCC_DIV && step_reg)
            occ_out_reg <= (resid >= RW'(DENOM)) ? quo_reg + 1'b1 : quo_reg;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign found = done_reg & found_reg;
    assign hit = done_reg & hit_reg;
    assign found_move = done_reg ? fe_reg.mv : '0;
    assign found_score = done_reg ? fe_reg.score : '0;
    assign found_kind = done_reg ? fe_reg.kind : '0;
    assign found_depth = done_reg ? fe_reg.depth : '0;
    assign occupancy_permille = done_reg ? occ_out_reg : '0;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> found) else $error("hit without found");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");

endmodule
